[sv/jsu_pkg.sv]
`default_nettype none

package jsu_pkg;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_REPLACE  = 21'h0FFFD;

    localparam int unsigned MAX_RES = 4;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_RES);

    typedef enum logic [5:0] {
        PH_NORMAL  = 6'b000001,
        PH_ESC     = 6'b000010,
        PH_HEX_HI  = 6'b000100,
        PH_WAIT_BS = 6'b001000,
        PH_WAIT_U  = 6'b010000,
        PH_HEX_LO  = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t        phase;
        logic [15:0]   high_code;
        logic [15:0]   low_code;
        logic [1:0]    hex_count;
        logic          error_seen;
    } jsu_state_t;

    localparam jsu_state_t STATE_RESET = '{
        phase:      PH_NORMAL,
        high_code:  16'h0000,
        low_code:   16'h0000,
        hex_count:  2'd0,
        error_seen: 1'b0
    };

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       string_end;
    } jsu_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       bad_escape;
    } jsu_out_t;

    // Results of one item, filled in order
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] data;
        logic [MAX_RES-1:0]      bad;
        logic [CNT_W-1:0]        cnt;
    } jsu_grp_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } esc_map_t;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c inside {[8'h30:8'h39]}) begin
            v = 5'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]}) begin
            v = 5'(c - 8'h57);
        end
        else if (c inside {[8'h41:8'h46]}) begin
            v = 5'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic esc_map_t esc_map(input logic [7:0] c);
        esc_map_t m;
        m.hit = 1'b1;
        case (c)
            CH_QUOTE:  m.value = CH_QUOTE;
            CH_BSLASH: m.value = CH_BSLASH;
            CH_SLASH:  m.value = CH_SLASH;
            CH_B:      m.value = CTL_BS;
            CH_F:      m.value = CTL_FF;
            CH_N:      m.value = CTL_LF;
            CH_R:      m.value = CTL_CR;
            CH_T:      m.value = CTL_TAB;
            default:
            begin
                m.hit   = 1'b0;
                m.value = 8'h00;
            end
        endcase
        return m;
    endfunction

    function automatic jsu_grp_t grp_put(input jsu_grp_t g, input logic [7:0] b,
                                         input logic bad);
        jsu_grp_t r;
        r = g;
        if (g.cnt < CNT_W'(MAX_RES)) begin
            r.data[g.cnt[IDX_W-1:0]] = b;
            r.bad[g.cnt[IDX_W-1:0]]  = bad;
            r.cnt = g.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    // UTF-8 encode of one code point
    function automatic jsu_grp_t grp_put_cp(input jsu_grp_t g, input logic [20:0] cp);
        jsu_grp_t r;
        r = g;
        if (cp < 21'h80) begin
            r = grp_put(r, {1'b0, cp[6:0]}, 1'b0);
        end
        else if (cp < 21'h800) begin
            r = grp_put(r, {3'b110, cp[10:6]}, 1'b0);
            r = grp_put(r, {2'b10, cp[5:0]}, 1'b0);
        end
        else if (cp < SUPP_BASE) begin
            r = grp_put(r, {4'b1110, cp[15:12]}, 1'b0);
            r = grp_put(r, {2'b10, cp[11:6]}, 1'b0);
            r = grp_put(r, {2'b10, cp[5:0]}, 1'b0);
        end
        else begin
            r = grp_put(r, {5'b11110, cp[20:18]}, 1'b0);
            r = grp_put(r, {2'b10, cp[17:12]}, 1'b0);
            r = grp_put(r, {2'b10, cp[11:6]}, 1'b0);
            r = grp_put(r, {2'b10, cp[5:0]}, 1'b0);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/json_string_unescape_utf8_core.sv]
// JSON string unescaper, raw string body bytes in, UTF-8 bytes out.
//
// Input channel (byte_valid / byte_stall / byte_item): one raw byte of a
// string body per item; string_end marks the last byte of the string.
// Output channel (res_valid / res_stall / res_item): one decoded byte per
// item. An input item gives zero to four result items; run_last marks the
// last one of that group, bad_escape flags the single error item of a
// malformed escape (its out_byte is zero). After an error the rest of the
// string gives nothing until string_end.
// An accepted byte is held in the input register while it is decoded;
// its results are then loaded into the group register feeding the port.
// Throughput: one input item per cycle while each gives at most one
// result and the output does not stall; the single-entry group register
// sends a group one byte per cycle unless stalled; a new group loads once
// the last byte is taken. Items giving no result pass without waiting.
// Reset: decode state returns to normal text, both stages empty.
// A stall on the output holds the current byte steady; the input stage
// then fills and byte_stall rises until the group register frees.
`default_nettype none

module json_string_unescape_utf8_core (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    byte_valid,
    output logic                   byte_stall,
    input  wire jsu_pkg::jsu_in_t  byte_item,
    output logic                   res_valid,
    input  wire                    res_stall,
    output jsu_pkg::jsu_out_t      res_item
);

    // input register
    jsu_pkg::jsu_in_t    in_reg;
    logic                in_vld_reg;
    logic                in_vld_next;

    // decode state
    jsu_pkg::jsu_state_t st_reg;
    jsu_pkg::jsu_state_t st_next;

    // result group register and read index
    jsu_pkg::jsu_grp_t   dec_grp;
    jsu_pkg::jsu_grp_t   grp_reg;
    logic                grp_vld_reg;
    logic                grp_vld_next;
    logic [jsu_pkg::IDX_W-1:0] idx_reg;
    logic [jsu_pkg::IDX_W-1:0] idx_next;

    logic                byte_take;
    logic                res_take;
    logic                grp_done;
    logic                is_last;
    logic                advance;
    logic                grp_load;

    jsu_step u_step (
        .st      (st_reg),
        .item    (in_reg),
        .st_next (st_next),
        .grp     (dec_grp)
    );

    assign is_last  = (jsu_pkg::CNT_W'(idx_reg) + jsu_pkg::CNT_W'(1)) == grp_reg.cnt;
    assign res_take = res_valid && !res_stall;
    assign grp_done = res_take && is_last;

    // an item with no result never waits for the output side
    assign advance  = in_vld_reg &&
                      (dec_grp.cnt == '0 || !grp_vld_reg || grp_done);
    assign grp_load = advance && (dec_grp.cnt != '0);

    assign byte_stall = in_vld_reg && !advance;
    assign byte_take  = byte_valid && !byte_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (byte_take) begin
            in_vld_next = 1'b1;
        end
        else if (advance) begin
            in_vld_next = 1'b0;
        end

        grp_vld_next = grp_vld_reg;
        idx_next     = idx_reg;
        if (grp_load) begin
            grp_vld_next = 1'b1;
            idx_next     = '0;
        end
        else if (grp_done) begin
            grp_vld_next = 1'b0;
        end
        else if (res_take) begin
            idx_next = idx_reg + jsu_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            grp_vld_reg <= 1'b0;
            idx_reg     <= '0;
            st_reg      <= jsu_pkg::STATE_RESET;
        end
        else begin
            in_vld_reg  <= in_vld_next;
            grp_vld_reg <= grp_vld_next;
            idx_reg     <= idx_next;
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take) begin
            in_reg <= byte_item;
        end
        if (grp_load) begin
            grp_reg <= dec_grp;
        end
    end

    assign res_valid           = grp_vld_reg;
    assign res_item.out_byte   = grp_reg.data[idx_reg];
    assign res_item.bad_escape = grp_reg.bad[idx_reg];
    assign res_item.run_last   = is_last;

`ifndef NO_ASSERTIONS
    // read index always inside the loaded group
    assert property (@(posedge clk) disable iff (!rst_n)
        grp_vld_reg |-> (jsu_pkg::CNT_W'(idx_reg) < grp_reg.cnt))
        else $error("result index beyond group");

    // the error item is always last of its group and carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.bad_escape) |->
        (res_item.run_last && res_item.out_byte == 8'h00))
        else $error("error item not last or not zero");

    // end of string returns decode state to reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.string_end) |=> (st_reg == jsu_pkg::STATE_RESET))
        else $error("state not cleared at string end");

    // no new group may overwrite one still being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        (grp_load && grp_vld_reg) |-> grp_done)
        else $error("group overwritten before drained");
`endif

endmodule

`default_nettype wire

[sv/jsu_step.sv]
`default_nettype none

// One decode step: state and one raw byte in, next state and results out.
module jsu_step (
    input  wire jsu_pkg::jsu_state_t st,
    input  wire jsu_pkg::jsu_in_t    item,
    output jsu_pkg::jsu_state_t      st_next,
    output jsu_pkg::jsu_grp_t        grp
);

    logic [4:0]          hexd;
    logic [15:0]         high_new;
    logic [15:0]         low_new;
    logic                esc_now;
    jsu_pkg::esc_map_t   em;
    jsu_pkg::jsu_state_t nx;
    jsu_pkg::jsu_grp_t   g;

    assign hexd     = jsu_pkg::hex_val(item.raw_byte);
    assign high_new = {st.high_code[11:0], hexd[3:0]};
    assign low_new  = {st.low_code[11:0], hexd[3:0]};
    assign em       = jsu_pkg::esc_map(item.raw_byte);

    always_comb
    begin
        nx      = st;
        g       = '0;
        esc_now = 1'b0;
        if (!st.error_seen) begin
            case (st.phase)
                jsu_pkg::PH_ESC:
                begin
                    esc_now = 1'b1;
                end
                jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO:
                begin
                    if (hexd[4]) begin
                        nx.error_seen = 1'b1;
                        nx.phase      = jsu_pkg::PH_NORMAL;
                        g = jsu_pkg::grp_put(g, 8'h00, 1'b1);
                    end
                    else begin
                        if (st.phase == jsu_pkg::PH_HEX_HI) begin
                            nx.high_code = high_new;
                        end
                        else begin
                            nx.low_code = low_new;
                        end
                        if (st.hex_count != 2'd3) begin
                            nx.hex_count = st.hex_count + 2'd1;
                        end
                        else begin
                            nx.hex_count = 2'd0;
                            nx.phase     = jsu_pkg::PH_NORMAL;
                            if (st.phase == jsu_pkg::PH_HEX_HI) begin
                                if (high_new inside {[jsu_pkg::HI_SURR_MIN:
                                                      jsu_pkg::HI_SURR_MAX]}) begin
                                    nx.phase = jsu_pkg::PH_WAIT_BS;
                                end
                                else begin
                                    g = jsu_pkg::grp_put_cp(g, {5'd0, high_new});
                                end
                            end
                            else if (low_new inside {[jsu_pkg::LO_SURR_MIN:
                                                      jsu_pkg::LO_SURR_MAX]}) begin
                                // pair: 0x10000 + high[9:0]:low[9:0]
                                g = jsu_pkg::grp_put_cp(g, jsu_pkg::SUPP_BASE +
                                    {1'b0, st.high_code[9:0], low_new[9:0]});
                            end
                            else begin
                                g = jsu_pkg::grp_put_cp(g, jsu_pkg::CP_REPLACE);
                            end
                        end
                    end
                end
                jsu_pkg::PH_WAIT_BS:
                begin
                    if (item.raw_byte == jsu_pkg::CH_BSLASH) begin
                        nx.phase = jsu_pkg::PH_WAIT_U;
                    end
                    else begin
                        g = jsu_pkg::grp_put_cp(g, jsu_pkg::CP_REPLACE);
                        g = jsu_pkg::grp_put(g, item.raw_byte, 1'b0);
                        nx.phase = jsu_pkg::PH_NORMAL;
                    end
                end
                jsu_pkg::PH_WAIT_U:
                begin
                    if (item.raw_byte == jsu_pkg::CH_U) begin
                        nx.phase     = jsu_pkg::PH_HEX_LO;
                        nx.low_code  = 16'h0000;
                        nx.hex_count = 2'd0;
                    end
                    else begin
                        g = jsu_pkg::grp_put_cp(g, jsu_pkg::CP_REPLACE);
                        esc_now = 1'b1;
                    end
                end
                default:
                begin
                    if (item.raw_byte == jsu_pkg::CH_BSLASH) begin
                        nx.phase = jsu_pkg::PH_ESC;
                    end
                    else begin
                        g = jsu_pkg::grp_put(g, item.raw_byte, 1'b0);
                    end
                end
            endcase

            // escape character after a backslash
            if (esc_now) begin
                if (em.hit) begin
                    g = jsu_pkg::grp_put(g, em.value, 1'b0);
                    nx.phase = jsu_pkg::PH_NORMAL;
                end
                else if (item.raw_byte == jsu_pkg::CH_U) begin
                    nx.phase     = jsu_pkg::PH_HEX_HI;
                    nx.high_code = 16'h0000;
                    nx.hex_count = 2'd0;
                end
                else begin
                    nx.error_seen = 1'b1;
                    nx.phase      = jsu_pkg::PH_NORMAL;
                    g = jsu_pkg::grp_put(g, 8'h00, 1'b1);
                end
            end
        end

        // string end: flush what is pending, then back to reset state
        if (item.string_end) begin
            if (!nx.error_seen) begin
                if (nx.phase == jsu_pkg::PH_WAIT_BS) begin
                    g = jsu_pkg::grp_put_cp(g, jsu_pkg::CP_REPLACE);
                end
                else if (nx.phase == jsu_pkg::PH_WAIT_U) begin
                    g = jsu_pkg::grp_put_cp(g, jsu_pkg::CP_REPLACE);
                    g = jsu_pkg::grp_put(g, 8'h00, 1'b1);
                end
                else if (nx.phase == jsu_pkg::PH_ESC || nx.phase == jsu_pkg::PH_HEX_HI ||
                         nx.phase == jsu_pkg::PH_HEX_LO) begin
                    g = jsu_pkg::grp_put(g, 8'h00, 1'b1);
                end
            end
            nx = jsu_pkg::STATE_RESET;
        end
    end

    assign st_next = nx;
    assign grp     = g;

endmodule

`default_nettype wire
